### src/eiph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet IP header parser package
// Shared constants, types and the transport offset helper.
// ----------------------------------------------------------------------------
package eiph_pkg;

   localparam int DEFAULT_LENGTH_BITS = 16;

   localparam logic [15:0] KIND_V4        = 16'h0800;
   localparam logic [15:0] KIND_V6        = 16'h86DD;
   localparam logic [15:0] FRAG_RESERVED  = 16'h8000;
   localparam logic [15:0] FRAG_MF_OFFSET = 16'h3FFF;
   localparam logic [3:0]  IHL_MIN        = 4'd5;

   localparam logic [7:0] ETH_HDR_LEN = 8'd14;
   localparam logic [7:0] V4_HDR_LEN  = 8'd20;
   localparam logic [7:0] V6_HDR_LEN  = 8'd40;
   localparam logic [7:0] TCP_HDR_LEN = 8'd20;
   localparam logic [7:0] UDP_HDR_LEN = 8'd8;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_FRAG = 8'd44;

   typedef enum logic [1:0] {
      FAMILY_NONE = 2'd0,
      FAMILY_V4   = 2'd1,
      FAMILY_V6   = 2'd2
   } family_type;

   // Header fields gathered while the frame streams in.
   typedef struct packed {
      logic [15:0] ether_kind;
      logic [3:0]  ihl;
      logic [15:0] frag_field;
      logic [7:0]  proto;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [31:0] port_pair;
      logic [15:0] tcp_bytes;
   } hdr_state_type;

   typedef struct packed {
      logic        frame_ok;
      family_type  family;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [7:0]  protocol;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [7:0]  tcp_offset_byte;
      logic [7:0]  tcp_flags;
      logic        fragmented;
      logic [15:0] frame_length;
   } summary_type;

   // Byte position where the transport header starts.
   function automatic logic [7:0] transport_start(input logic [15:0] kind,
                                                  input logic [3:0]  ihl);
      if (kind == KIND_V6) begin
         return ETH_HDR_LEN + V6_HDR_LEN;
      end
      return ETH_HDR_LEN + {2'b00, ihl, 2'b00};
   endfunction

endpackage
`default_nettype wire

### src/eiph_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet IP header parser channels
// Valid/ready channels for frame bytes and frame summaries.
// ----------------------------------------------------------------------------
interface eiph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface eiph_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [1:0]  family;
   logic [63:0] addr_upper;
   logic [63:0] addr_lower;
   logic [7:0]  protocol;
   logic [15:0] dst_port;
   logic [15:0] src_port;
   logic [7:0]  tcp_offset_byte;
   logic [7:0]  tcp_flags;
   logic        fragmented;
   logic [15:0] frame_length;

   modport source (output valid, output frame_ok, output family, output addr_upper,
                   output addr_lower, output protocol, output dst_port,
                   output src_port, output tcp_offset_byte, output tcp_flags,
                   output fragmented, output frame_length, input ready);
   modport sink   (input valid, input frame_ok, input family, input addr_upper,
                   input addr_lower, input protocol, input dst_port,
                   input src_port, input tcp_offset_byte, input tcp_flags,
                   input fragmented, input frame_length, output ready);
endinterface
`default_nettype wire

### src/ethernet_ip_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet IP header parser
// Parses an Ethernet frame byte by byte and reports one summary per frame.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                              Meaning
// req_chan  in   data_byte, frame_end                 one frame byte per request
// rsp_chan  out  frame_ok .. frame_length             one summary per frame
//
// One byte is taken every cycle unless a final byte is held back by a waiting
// summary; a request moves from the input register through the capture logic,
// and a frame summary is valid from the edge at which the final byte leaves
// the input register.
// Reset (synchronous) empties both registers and clears the header fields.
// A waiting summary stalls only a final byte behind it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ethernet_ip_header_parser_unit
   import eiph_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   eiph_req_if.sink   req_chan,
   eiph_rsp_if.source rsp_chan
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   summary_type rsp_ff;

   logic                   advance, step;
   hdr_state_type          hdr_next;
   logic [LENGTH_BITS-1:0] len_next;
   summary_type            summary;

   // A final byte may only move on when the result register can take its summary.
   assign advance = !(in_end_ff && rsp_valid_ff && !rsp_chan.ready);
   assign step    = in_valid_ff && advance;

   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = (step && in_end_ff) ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   eiph_capture #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .frame_end (in_end_ff),
      .hdr_next  (hdr_next),
      .len_next  (len_next)
   );

   eiph_decide #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_decide (
      .hdr     (hdr_next),
      .len     (len_next),
      .summary (summary)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= in_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.frame_end;
      end
      if (step && in_end_ff) begin
         rsp_ff <= summary;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.frame_ok        = rsp_ff.frame_ok;
   assign rsp_chan.family          = rsp_ff.family;
   assign rsp_chan.addr_upper      = rsp_ff.addr_upper;
   assign rsp_chan.addr_lower      = rsp_ff.addr_lower;
   assign rsp_chan.protocol        = rsp_ff.protocol;
   assign rsp_chan.dst_port        = rsp_ff.dst_port;
   assign rsp_chan.src_port        = rsp_ff.src_port;
   assign rsp_chan.tcp_offset_byte = rsp_ff.tcp_offset_byte;
   assign rsp_chan.tcp_flags       = rsp_ff.tcp_flags;
   assign rsp_chan.fragmented      = rsp_ff.fragmented;
   assign rsp_chan.frame_length    = rsp_ff.frame_length;

`ifndef SYNTH
   // A new summary appears only after a final byte went through capture.
   a_rsp_from_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_chan.ready)) |->
         $past(step && in_end_ff))
      else $error("summary without a final byte");

   // A rejected frame carries nothing but its length.
   a_reject_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.frame_ok) |->
         (rsp_ff.family == FAMILY_NONE && rsp_ff.protocol == 8'd0 &&
          rsp_ff.addr_upper == 64'd0 && rsp_ff.addr_lower == 64'd0 &&
          rsp_ff.src_port == 16'd0 && rsp_ff.dst_port == 16'd0 &&
          !rsp_ff.fragmented))
      else $error("rejected frame with fields set");

   // An accepted frame always names its family.
   a_ok_family : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_ok) |->
         (rsp_ff.family == FAMILY_V4 || rsp_ff.family == FAMILY_V6))
      else $error("accepted frame without family");

   // Transport fields are only reported for unfragmented TCP or UDP.
   a_ports_proto : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.src_port != 16'd0 || rsp_ff.dst_port != 16'd0)) |->
         ((rsp_ff.protocol == PROTO_TCP || rsp_ff.protocol == PROTO_UDP) &&
          !rsp_ff.fragmented))
      else $error("ports reported for non-transport frame");

   // TCP header bytes never appear for anything but TCP.
   a_tcp_only : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.tcp_flags != 8'd0 || rsp_ff.tcp_offset_byte != 8'd0)) |->
         (rsp_ff.protocol == PROTO_TCP))
      else $error("TCP bytes reported for non-TCP frame");
`endif

endmodule
`default_nettype wire

### src/eiph_capture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet IP header parser field capture
// Byte counter and position-keyed capture of the header fields.
// ----------------------------------------------------------------------------
module eiph_capture
   import eiph_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   frame_end,
   output hdr_state_type               hdr_next,
   output logic [LENGTH_BITS-1:0]      len_next
);

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   hdr_state_type          hdr_ff, hdr_in;

   logic                   is_v4, is_v6, in_ip, l4_open;
   logic [LENGTH_BITS-1:0] t_start, rel;

   always_comb begin
      is_v4   = (hdr_ff.ether_kind == KIND_V4);
      is_v6   = (hdr_ff.ether_kind == KIND_V6);
      in_ip   = (pos_ff >= LENGTH_BITS'(ETH_HDR_LEN));
      t_start = LENGTH_BITS'(transport_start(hdr_ff.ether_kind, hdr_ff.ihl));
      rel     = pos_ff - t_start;
      l4_open = ((is_v4 && hdr_ff.ihl >= IHL_MIN &&
                  pos_ff >= LENGTH_BITS'(ETH_HDR_LEN + V4_HDR_LEN)) ||
                 (is_v6 && pos_ff >= LENGTH_BITS'(ETH_HDR_LEN + V6_HDR_LEN))) &&
                (pos_ff >= t_start);

      hdr_next = hdr_ff;
      if (pos_ff == LENGTH_BITS'(12) || pos_ff == LENGTH_BITS'(13)) begin
         hdr_next.ether_kind = {hdr_ff.ether_kind[7:0], data_byte};
      end
      if (is_v4 && in_ip) begin
         if (pos_ff == LENGTH_BITS'(14)) begin
            hdr_next.ihl = data_byte[3:0];
         end
         if (pos_ff == LENGTH_BITS'(20) || pos_ff == LENGTH_BITS'(21)) begin
            hdr_next.frag_field = {hdr_ff.frag_field[7:0], data_byte};
         end
         if (pos_ff == LENGTH_BITS'(23)) begin
            hdr_next.proto = data_byte;
         end
         if (pos_ff >= LENGTH_BITS'(26) && pos_ff <= LENGTH_BITS'(29)) begin
            hdr_next.src_lo = {32'd0, hdr_ff.src_lo[23:0], data_byte};
         end
      end else if (is_v6 && in_ip) begin
         if (pos_ff == LENGTH_BITS'(20)) begin
            hdr_next.proto = data_byte;
         end
         if (pos_ff >= LENGTH_BITS'(22) && pos_ff <= LENGTH_BITS'(29)) begin
            hdr_next.src_hi = {hdr_ff.src_hi[55:0], data_byte};
         end
         if (pos_ff >= LENGTH_BITS'(30) && pos_ff <= LENGTH_BITS'(37)) begin
            hdr_next.src_lo = {hdr_ff.src_lo[55:0], data_byte};
         end
      end
      if (l4_open) begin
         if (rel < LENGTH_BITS'(4)) begin
            hdr_next.port_pair = {hdr_ff.port_pair[23:0], data_byte};
         end
         if (rel == LENGTH_BITS'(12) || rel == LENGTH_BITS'(13)) begin
            hdr_next.tcp_bytes = {hdr_ff.tcp_bytes[7:0], data_byte};
         end
      end

      // The byte count holds at its ceiling on very long frames.
      len_next = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   end

   always_comb begin
      if (frame_end) begin
         pos_in = '0;
         hdr_in = '0;
      end else begin
         pos_in = len_next;
         hdr_in = hdr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hdr_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule
`default_nettype wire

### src/eiph_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet IP header parser decision
// Validates the gathered headers against the frame length and forms the summary.
// ----------------------------------------------------------------------------
module eiph_decide
   import eiph_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  wire hdr_state_type          hdr,
   input  wire logic [LENGTH_BITS-1:0] len,
   output summary_type                 summary
);

   localparam int WIDE_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   logic                   is_v4, is_v6, ok, frag, l4;
   logic [LENGTH_BITS-1:0] t_start;
   logic [WIDE_BITS-1:0]   len_wide;

   always_comb begin
      is_v4    = (hdr.ether_kind == KIND_V4);
      is_v6    = (hdr.ether_kind == KIND_V6);
      t_start  = LENGTH_BITS'(transport_start(hdr.ether_kind, hdr.ihl));
      len_wide = WIDE_BITS'(len);

      ok   = 1'b0;
      frag = 1'b0;
      if (is_v4) begin
         ok   = (len >= LENGTH_BITS'(ETH_HDR_LEN + V4_HDR_LEN)) &&
                (hdr.ihl >= IHL_MIN) && (len >= t_start) &&
                ((hdr.frag_field & FRAG_RESERVED) == 16'd0);
         frag = ((hdr.frag_field & FRAG_MF_OFFSET) != 16'd0);
      end else if (is_v6) begin
         ok   = (len >= LENGTH_BITS'(ETH_HDR_LEN + V6_HDR_LEN));
         frag = (hdr.proto == PROTO_FRAG);
      end
      l4 = ok && !frag;

      summary = '0;
      summary.frame_length = (len_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF
                                                              : len_wide[15:0];
      if (ok) begin
         summary.frame_ok   = 1'b1;
         summary.family     = is_v6 ? FAMILY_V6 : FAMILY_V4;
         summary.addr_upper = is_v6 ? hdr.src_hi : 64'd0;
         summary.addr_lower = is_v6 ? hdr.src_lo : {32'd0, hdr.src_lo[31:0]};
         summary.protocol   = hdr.proto;
         summary.fragmented = frag;
      end
      if (l4) begin
         if (hdr.proto == PROTO_TCP && len >= t_start + LENGTH_BITS'(TCP_HDR_LEN)) begin
            summary.dst_port        = hdr.port_pair[15:0];
            summary.src_port        = hdr.port_pair[31:16];
            summary.tcp_offset_byte = hdr.tcp_bytes[15:8];
            summary.tcp_flags       = hdr.tcp_bytes[7:0];
         end else if (hdr.proto == PROTO_UDP &&
                      len >= t_start + LENGTH_BITS'(UDP_HDR_LEN)) begin
            summary.dst_port = hdr.port_pair[15:0];
            summary.src_port = hdr.port_pair[31:16];
         end
      end
   end

endmodule
`default_nettype wire
